[rtl/core/psp_pkg.sv]
// ----------------------------------------------------------------------------
// Pedal solenoid pump controller package
// Shared widths, reset values, register indexes, mode codes and types.
// ----------------------------------------------------------------------------
package psp_pkg;

  // Field and register widths
  localparam int unsigned THR_W      = 10;
  localparam int unsigned DEB_W      = 8;
  localparam int unsigned SCALE_W    = 4;
  localparam int unsigned RUN_ON_W   = 14;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SAMPLE_IN_W = 10;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  // Default converter resolution
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  // Longest run-on time that the countdown can hold
  localparam logic [RUN_ON_W-1:0] RUN_ON_MAX = '1;

  // Register reset values
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = 8'd10;
  localparam logic [THR_W-1:0]   DIRECT_RST    = 10'd33;
  localparam logic [THR_W-1:0]   PERMANENT_RST = 10'h3F0;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 4'd6;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_DIRECT    = 2'd1,
    REG_PERMANENT = 2'd2,
    REG_SCALE     = 2'd3
  } cfg_reg_t;

  // Pump modes
  typedef enum logic [1:0] {
    MODE_DIRECT    = 2'd0,
    MODE_TIMEOUT   = 2'd1,
    MODE_PERMANENT = 2'd2
  } mode_t;

  // Current configuration, handed from the register file to the datapath
  typedef struct packed {
    logic [DEB_W-1:0]   debounce_ticks;
    logic [THR_W-1:0]   direct_threshold;
    logic [THR_W-1:0]   permanent_threshold;
    logic [SCALE_W-1:0] timeout_scale;
  } psp_cfg_t;

endpackage

[rtl/core/psp_regs.sv]
// ----------------------------------------------------------------------------
// Pedal solenoid pump controller configuration registers
// Holds the four settings and takes a write on every transaction of the port.
// ----------------------------------------------------------------------------
module psp_regs
  import psp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output psp_cfg_t              cfg
);

  psp_cfg_t cfg_r;

  // The register file is always able to take a write.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register writes, truncated to each register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks      <= DEBOUNCE_RST;
      cfg_r.direct_threshold    <= DIRECT_RST;
      cfg_r.permanent_threshold <= PERMANENT_RST;
      cfg_r.timeout_scale       <= SCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:  cfg_r.debounce_ticks      <= cfg_data[DEB_W-1:0];
        REG_DIRECT:    cfg_r.direct_threshold    <= cfg_data[THR_W-1:0];
        REG_PERMANENT: cfg_r.permanent_threshold <= cfg_data[THR_W-1:0];
        REG_SCALE:     cfg_r.timeout_scale       <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/pedal_solenoid_pump_controller.sv]
// ----------------------------------------------------------------------------
// Pedal solenoid pump controller
// Debounces the pedal, selects the pump mode from potentiometer samples and
// drives the solenoid valve and pump, one tick per input transaction.
// ----------------------------------------------------------------------------
// A result passes the input register, then the state update into the result register.
// Throughput: one tick per cycle while results are taken; the single state update step sets this rate.
// Reset: synchronous, active low; clears the valid flags and controller state, loads register defaults.
// No clearing pass: the block can accept a tick as soon as reset is released.
module pedal_solenoid_pump_controller
  import psp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Tick input
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] pedal_level, [10:1] pot_sample, rest zero
  input  logic                   in_tuser,   // [0] sample_valid
  // Drive result
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] solenoid_open, [1] pump_run, [3:2] mode_now
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Usable sample bits and the width of the run-on product
  localparam int unsigned SAMPLE_W = (SAMPLE_BITS < THR_W) ? SAMPLE_BITS : THR_W;
  localparam int unsigned PROD_W   = SAMPLE_W + SCALE_W;
  localparam int unsigned EXT_W    = (PROD_W > RUN_ON_W) ? PROD_W : RUN_ON_W;

  psp_cfg_t cfg;

  psp_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  logic                   item_v_r;
  logic                   item_pedal_r;
  logic                   item_sv_r;
  logic [SAMPLE_IN_W-1:0] item_sample_r;

  // Controller state
  logic [DEB_W-1:0]    ignore_count_r, ignore_count_nxt;
  logic                last_pedal_r, last_pedal_nxt;
  mode_t               mode_r, mode_nxt;
  logic [RUN_ON_W-1:0] run_on_time_r, run_on_time_nxt;
  logic [RUN_ON_W-1:0] run_on_left_r, run_on_left_nxt;
  logic                valve_r, valve_nxt;
  logic                pump_nxt;

  // Result register
  logic  out_v_r;
  logic  out_sol_r;
  logic  out_pump_r;
  mode_t out_mode_r;

  logic                out_free;
  logic                fire;
  logic [SAMPLE_W-1:0] sample;
  logic [EXT_W-1:0]    prod;
  logic [RUN_ON_W-1:0] reload;

  // Handshake: the result register frees when empty or being taken.
  assign out_free  = !out_v_r || out_tready;
  assign fire      = item_v_r && out_free;
  assign in_tready = !item_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tready) begin
      item_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_pedal_r  <= in_tdata[0];
      item_sv_r     <= in_tuser;
      item_sample_r <= in_tdata[SAMPLE_IN_W:1];
    end
  end

  assign sample = item_sample_r[SAMPLE_W-1:0];
  assign prod   = EXT_W'(sample) * EXT_W'(cfg.timeout_scale);

  // One tick of the controller: mode, debounce, valve, pump and countdown.
  always_comb begin
    mode_nxt         = mode_r;
    run_on_time_nxt  = run_on_time_r;
    ignore_count_nxt = ignore_count_r;
    last_pedal_nxt   = last_pedal_r;
    valve_nxt        = valve_r;
    run_on_left_nxt  = run_on_left_r;
    reload           = '0;

    // A new sample picks the mode; permanent wins where thresholds overlap.
    if (item_sv_r) begin
      if (THR_W'(sample) >= cfg.permanent_threshold) begin
        mode_nxt        = MODE_PERMANENT;
        run_on_time_nxt = '0;
      end else if (THR_W'(sample) <= cfg.direct_threshold) begin
        mode_nxt        = MODE_DIRECT;
        run_on_time_nxt = '0;
      end else begin
        mode_nxt        = MODE_TIMEOUT;
        run_on_time_nxt = (prod > EXT_W'(RUN_ON_MAX)) ? RUN_ON_MAX : RUN_ON_W'(prod);
      end
    end

    // Debounce: an edge starts the hold-off, during which the valve keeps its state.
    if (ignore_count_r == '0) begin
      if (last_pedal_r != item_pedal_r) begin
        ignore_count_nxt = cfg.debounce_ticks;
      end
      last_pedal_nxt = item_pedal_r;
      valve_nxt      = item_pedal_r;
      if (item_pedal_r) begin
        run_on_left_nxt = run_on_time_nxt;
      end
    end else begin
      ignore_count_nxt = ignore_count_r - 1'b1;
    end

    pump_nxt = valve_nxt || (mode_nxt == MODE_PERMANENT) ||
               ((mode_nxt == MODE_TIMEOUT) && (run_on_left_nxt != '0));

    // Clamp the countdown to the current run-on time, then count down.
    reload = (run_on_left_nxt > run_on_time_nxt) ? run_on_time_nxt : run_on_left_nxt;
    run_on_left_nxt = (reload != '0) ? reload - 1'b1 : reload;
  end

  // State update, taken together with the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_count_r <= '0;
      last_pedal_r   <= 1'b0;
      mode_r         <= MODE_DIRECT;
      run_on_time_r  <= '0;
      run_on_left_r  <= '0;
      valve_r        <= 1'b0;
    end else if (fire) begin
      ignore_count_r <= ignore_count_nxt;
      last_pedal_r   <= last_pedal_nxt;
      mode_r         <= mode_nxt;
      run_on_time_r  <= run_on_time_nxt;
      run_on_left_r  <= run_on_left_nxt;
      valve_r        <= valve_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_sol_r  <= valve_nxt;
      out_pump_r <= pump_nxt;
      out_mode_r <= mode_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_mode_r, out_pump_r, out_sol_r};

  // The countdown never exceeds the run-on time once a tick is done.
  a_left_le_time: assert property (@(posedge clk) disable iff (!rst_n)
    run_on_left_r <= run_on_time_r)
    else $error("run-on countdown above run-on time");

  // Only timeout mode carries a run-on time.
  a_time_only_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_TIMEOUT) |-> (run_on_time_r == '0))
    else $error("run-on time held outside timeout mode");

  // During the hold-off the valve keeps its state.
  a_holdoff_valve: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (ignore_count_r != '0)) |=> (valve_r == $past(valve_r)))
    else $error("valve changed during debounce hold-off");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |-> !fire)
    else $error("result overwritten while stalled");

  // An open valve always runs the pump.
  a_valve_pump: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_sol_r) |-> out_pump_r)
    else $error("valve open without pump");

endmodule
